>>> hdl/stt_pkg.sv
package stt_pkg;

  localparam int TimeW     = 48;
  localparam int PeriodW   = 35;
  localparam int GenW      = 32;
  localparam int MsW       = 24;
  localparam int UsPerMs   = 1000;
  localparam int MaxFired  = 16;
  localparam int FireCntW  = 5;

  localparam logic [TimeW-1:0] TimeMax = '1;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_CLEAR  = 2'd3
  } item_kind_t;

  typedef enum logic [2:0] {
    RES_ADD_OK  = 3'd0,
    RES_FULL    = 3'd1,
    RES_DONE    = 3'd2,
    RES_FIRED   = 3'd3,
    RES_SUMMARY = 3'd4
  } result_kind_t;

  typedef struct packed {
    item_kind_t        kind;
    logic [MsW-1:0]    delay_ms;
    logic              repeating;
    logic [3:0]        handle_slot;
    logic [GenW-1:0]   handle_gen;
    logic [TimeW-1:0]  now_us;
  } in_item_t;

  typedef struct packed {
    result_kind_t      result_kind;
    logic [3:0]        slot_out;
    logic [GenW-1:0]   gen_out;
    logic [TimeW-1:0]  soonest_us;
    logic              soonest_valid;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [TimeW-1:0]   deadline;
    logic [PeriodW-1:0] period;
    logic [GenW-1:0]    gen;
  } slot_entry_t;

  typedef struct packed {
    logic              due;
    logic              rearm;
    logic [TimeW-1:0]  deadline_nxt;
    logic              earlier;
  } slot_eval_t;

  function automatic logic [TimeW-1:0] sat_add_time(input logic [TimeW-1:0] t,
                                                    input logic [PeriodW-1:0] d);
    logic [TimeW:0] s;
    s = {1'b0, t} + (TimeW+1)'(d);
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

endpackage

>>> hdl/stt_if.sv
interface stt_in_if import stt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface stt_out_if import stt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/stt_slot_eval.sv
module stt_slot_eval import stt_pkg::*; (
  input  slot_entry_t      entry,
  input  logic [TimeW-1:0] now_us,
  input  logic [TimeW-1:0] soon_us,
  output slot_eval_t       ev
);

  always_comb begin
    ev.due          = (entry.deadline <= now_us);
    ev.rearm        = (entry.period != '0);
    // re-arm from the current time, not from the old deadline
    ev.deadline_nxt = ev.due ? sat_add_time(now_us, entry.period) : entry.deadline;
    ev.earlier      = (ev.deadline_nxt < soon_us);
  end

endmodule

>>> hdl/software_timer_slot_table_core.sv
// Timer slot table: NUM_SLOTS timers, each with a deadline, a period and a
// generation count, kept in one slot memory with a registered read port;
// active and generation-written marks sit in flip-flops, so the block is
// ready right after reset with no clearing pass. One item is worked on at a
// time. An add scans the active marks from slot 0 up to the first free slot
// (over all slots when the table is full); a cancel or a clear is answered
// from its own state; a tick walks the slot memory one entry per cycle
// through its single read port, slot by slot, and then gives a summary. A
// waiting result stalls the walk only when a new result has to be shown.
// The next item is taken as soon as the last result of the current one is
// in the output register.
module software_timer_slot_table_core import stt_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  stt_in_if.sink        in_ch,
  stt_out_if.source     out_ch
);

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ADD_SCAN = 7'b0000010,
    S_ADD_WR   = 7'b0000100,
    S_CANCEL   = 7'b0001000,
    S_CLEAR    = 7'b0010000,
    S_TICK     = 7'b0100000,
    S_SUM      = 7'b1000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [IdxW-1:0]        idx_r, idx_nxt;
  logic [NUM_SLOTS-1:0]   active_r, active_nxt;
  logic [NUM_SLOTS-1:0]   gen_vld_r, gen_vld_nxt;
  logic [FireCntW-1:0]    fire_cnt_r, fire_cnt_nxt;
  logic [TimeW-1:0]       soon_r, soon_nxt;
  logic                   any_r, any_nxt;

  logic [TimeW-1:0]       now_r;
  logic                   rep_r;
  logic [GenW-1:0]        hgen_r;
  logic                   in_range_r;
  logic [PeriodW-1:0]     d_r;

  logic                   out_vld_r;
  out_item_t              out_r;

  slot_entry_t            mem [NUM_SLOTS];
  slot_entry_t            mem_q_r;
  logic                   mem_we;
  logic [IdxW-1:0]        mem_wa;
  slot_entry_t            mem_wd;
  logic [IdxW-1:0]        rd_addr;

  logic                   accept;
  logic                   in_ready;
  logic                   out_free;
  logic                   emit;
  out_item_t              emit_item;
  logic                   hslot_in_range;
  logic [IdxW-1:0]        hslot_idx;
  logic [MsW-1:0]         ms_clamped;
  logic [GenW-1:0]        gen_cur;
  logic                   report;
  slot_eval_t             ev;

  assign accept   = in_ch.valid && in_ready;
  assign out_free = !out_vld_r || out_ch.ready;

  assign hslot_in_range = (int'(in_ch.data.handle_slot) < NUM_SLOTS);
  assign hslot_idx      = hslot_in_range ? IdxW'(in_ch.data.handle_slot) : '0;
  assign ms_clamped     = (in_ch.data.delay_ms == '0) ? MsW'(1) : in_ch.data.delay_ms;

  // a slot whose generation was never written reads as generation zero
  assign gen_cur = gen_vld_r[idx_r] ? mem_q_r.gen : '0;

  stt_slot_eval u_eval (
    .entry   (mem_q_r),
    .now_us  (now_r),
    .soon_us (soon_r),
    .ev      (ev)
  );

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    active_nxt   = active_r;
    gen_vld_nxt  = gen_vld_r;
    fire_cnt_nxt = fire_cnt_r;
    soon_nxt     = soon_r;
    any_nxt      = any_r;
    in_ready     = 1'b0;
    emit         = 1'b0;
    emit_item    = '0;
    mem_we       = 1'b0;
    mem_wa       = idx_r;
    mem_wd       = mem_q_r;
    rd_addr      = idx_r;
    report       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = (in_ch.data.kind == KIND_CANCEL) ? hslot_idx : '0;
        if (in_ch.valid) begin
          unique case (in_ch.data.kind)
            KIND_ADD: begin
              idx_nxt   = '0;
              state_nxt = S_ADD_SCAN;
            end
            KIND_CANCEL: begin
              idx_nxt   = hslot_idx;
              state_nxt = S_CANCEL;
            end
            KIND_TICK: begin
              idx_nxt      = '0;
              fire_cnt_nxt = '0;
              soon_nxt     = TimeMax;
              any_nxt      = 1'b0;
              state_nxt    = S_TICK;
            end
            KIND_CLEAR: begin
              active_nxt = '0;
              state_nxt  = S_CLEAR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_ADD_SCAN: begin
        if (!active_r[idx_r]) begin
          // hold the address so the entry's generation is read next cycle
          state_nxt = S_ADD_WR;
        end else if (idx_r == LastIdx) begin
          if (out_free) begin
            emit                  = 1'b1;
            emit_item.result_kind = RES_FULL;
            emit_item.last        = 1'b1;
            state_nxt             = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + IdxW'(1);
        end
      end

      S_ADD_WR: begin
        if (out_free) begin
          mem_we              = 1'b1;
          mem_wd.deadline     = sat_add_time(now_r, d_r);
          mem_wd.period       = rep_r ? d_r : '0;
          mem_wd.gen          = gen_cur + GenW'(1);
          active_nxt[idx_r]   = 1'b1;
          gen_vld_nxt[idx_r]  = 1'b1;
          emit                  = 1'b1;
          emit_item.result_kind = RES_ADD_OK;
          emit_item.slot_out    = 4'(idx_r);
          emit_item.gen_out     = gen_cur + GenW'(1);
          emit_item.last        = 1'b1;
          state_nxt             = S_IDLE;
        end
      end

      S_CANCEL: begin
        if (out_free) begin
          if (in_range_r && active_r[idx_r] && (gen_cur == hgen_r)) begin
            active_nxt[idx_r] = 1'b0;
          end
          emit                  = 1'b1;
          emit_item.result_kind = RES_DONE;
          emit_item.last        = 1'b1;
          state_nxt             = S_IDLE;
        end
      end

      S_CLEAR: begin
        if (out_free) begin
          emit                  = 1'b1;
          emit_item.result_kind = RES_DONE;
          emit_item.last        = 1'b1;
          state_nxt             = S_IDLE;
        end
      end

      S_TICK: begin
        report = active_r[idx_r] && ev.due && (fire_cnt_r < FireCntW'(MaxFired));
        // stall on a busy output only when this slot has to be reported;
        // rd_addr stays on idx_r so the entry is still there next cycle
        if (!report || out_free) begin
          if (report) begin
            emit                  = 1'b1;
            emit_item.result_kind = RES_FIRED;
            emit_item.slot_out    = 4'(idx_r);
            emit_item.gen_out     = gen_cur;
            fire_cnt_nxt          = fire_cnt_r + FireCntW'(1);
          end
          if (active_r[idx_r]) begin
            if (ev.due && !ev.rearm) begin
              active_nxt[idx_r] = 1'b0;
            end else begin
              if (ev.due) begin
                mem_we          = 1'b1;
                mem_wd.deadline = ev.deadline_nxt;
              end
              any_nxt = 1'b1;
              if (ev.earlier) begin
                soon_nxt = ev.deadline_nxt;
              end
            end
          end
          if (idx_r == LastIdx) begin
            state_nxt = S_SUM;
          end else begin
            idx_nxt = idx_r + IdxW'(1);
            rd_addr = idx_r + IdxW'(1);
          end
        end
      end

      S_SUM: begin
        if (out_free) begin
          emit                    = 1'b1;
          emit_item.result_kind   = RES_SUMMARY;
          emit_item.soonest_us    = soon_r;
          emit_item.soonest_valid = any_r;
          emit_item.last          = 1'b1;
          state_nxt               = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      idx_r     <= '0;
      active_r  <= '0;
      gen_vld_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      active_r  <= active_nxt;
      gen_vld_r <= gen_vld_nxt;
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fire_cnt_r <= fire_cnt_nxt;
    soon_r     <= soon_nxt;
    any_r      <= any_nxt;
    if (emit) begin
      out_r <= emit_item;
    end
    if (accept) begin
      now_r      <= in_ch.data.now_us;
      rep_r      <= in_ch.data.repeating;
      hgen_r     <= in_ch.data.handle_gen;
      in_range_r <= hslot_in_range;
      d_r        <= PeriodW'(ms_clamped) * PeriodW'(UsPerMs);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[rd_addr];
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

endmodule

>>> hdl/stt_checker.sv
module stt_checker import stt_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // one item at a time: ready drops right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item was in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // only fired items are followed by more items of the same input
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.result_kind != RES_FIRED)))
    else $error("last flag does not match result kind");

  a_summary_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind != RES_SUMMARY) |->
      (out_data.soonest_us == '0) && !out_data.soonest_valid)
    else $error("soonest fields set outside a tick summary");

  a_empty_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == RES_SUMMARY) && !out_data.soonest_valid |->
      (out_data.soonest_us == TimeMax) && (out_data.slot_out == '0))
    else $error("empty tick summary has a bad soonest value");

endmodule

bind software_timer_slot_table_core stt_checker u_stt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

>>> tb/tb.sv
module tb;
  import stt_pkg::*;

  localparam int NUM_SLOTS   = 16;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 40;

  logic clk = 1'b0;
  logic rst_n;

  stt_in_if  in_ch ();
  stt_out_if out_ch ();

  software_timer_slot_table_core #(.NUM_SLOTS(NUM_SLOTS)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Own copy of the slot table, updated as each item is accepted.
  logic               tbl_active   [NUM_SLOTS];
  logic [TimeW-1:0]   tbl_deadline [NUM_SLOTS];
  logic [PeriodW-1:0] tbl_period   [NUM_SLOTS];
  logic [GenW-1:0]    tbl_gen      [NUM_SLOTS];

  out_item_t awaited_results [$];

  int          err_count     = 0;
  int          items_sent    = 0;
  int          results_seen  = 0;
  int          fired_count   = 0;
  int          full_count    = 0;
  int          cancel_hits   = 0;
  int          cycle_count   = 0;
  logic        hold_req      = 1'b0;
  logic        no_gaps       = 1'b0;
  logic [TimeW-1:0] wall_us;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_count, awaited_results.size());
      $display("tb: errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TimeW-1:0] deadline_after(input logic [TimeW-1:0] t,
                                                      input logic [PeriodW-1:0] d);
    logic [TimeW:0] sum;
    sum = t + d;
    if (sum > {1'b0, {TimeW{1'b1}}}) return {TimeW{1'b1}};
    return sum[TimeW-1:0];
  endfunction

  function automatic in_item_t make_item(input item_kind_t k, input logic [MsW-1:0] ms,
                                         input logic rep, input logic [3:0] hs,
                                         input logic [GenW-1:0] hg,
                                         input logic [TimeW-1:0] now);
    in_item_t it;
    it.kind        = k;
    it.delay_ms    = ms;
    it.repeating   = rep;
    it.handle_slot = hs;
    it.handle_gen  = hg;
    it.now_us      = now;
    return it;
  endfunction

  task automatic predict_timer_results(input in_item_t it);
    out_item_t          r;
    int                 s;
    int                 free_slot;
    int                 fired;
    longint unsigned    ms_val;
    logic [PeriodW-1:0] step_us;
    logic [TimeW-1:0]   soon;
    logic               any_left;
    r = '0;
    r.last = 1'b1;
    case (it.kind)
      KIND_ADD: begin
        free_slot = -1;
        for (s = NUM_SLOTS - 1; s >= 0; s--)
          if (!tbl_active[s]) free_slot = s;
        if (free_slot < 0) begin
          r.result_kind = RES_FULL;
          full_count++;
        end else begin
          ms_val  = (it.delay_ms == '0) ? 1 : it.delay_ms;
          step_us = PeriodW'(ms_val * UsPerMs);
          tbl_active[free_slot]   = 1'b1;
          tbl_period[free_slot]   = it.repeating ? step_us : '0;
          tbl_deadline[free_slot] = deadline_after(it.now_us, step_us);
          tbl_gen[free_slot]      = tbl_gen[free_slot] + 1'b1;
          r.result_kind = RES_ADD_OK;
          r.slot_out    = 4'(free_slot);
          r.gen_out     = tbl_gen[free_slot];
        end
        awaited_results.push_back(r);
      end
      KIND_CANCEL: begin
        if (tbl_active[it.handle_slot] && tbl_gen[it.handle_slot] == it.handle_gen) begin
          tbl_active[it.handle_slot] = 1'b0;
          cancel_hits++;
        end
        r.result_kind = RES_DONE;
        awaited_results.push_back(r);
      end
      KIND_CLEAR: begin
        for (s = 0; s < NUM_SLOTS; s++) tbl_active[s] = 1'b0;
        r.result_kind = RES_DONE;
        awaited_results.push_back(r);
      end
      default: begin
        fired    = 0;
        any_left = 1'b0;
        soon     = {TimeW{1'b1}};
        for (s = 0; s < NUM_SLOTS; s++) begin
          if (tbl_active[s]) begin
            if (tbl_deadline[s] <= it.now_us) begin
              if (fired < MaxFired) begin
                r = '0;
                r.result_kind = RES_FIRED;
                r.slot_out    = 4'(s);
                r.gen_out     = tbl_gen[s];
                awaited_results.push_back(r);
                fired++;
              end
              // re-arm from the tick time, or free a one-shot
              if (tbl_period[s] != '0) tbl_deadline[s] = deadline_after(it.now_us, tbl_period[s]);
              else tbl_active[s] = 1'b0;
            end
            if (tbl_active[s]) begin
              any_left = 1'b1;
              if (tbl_deadline[s] < soon) soon = tbl_deadline[s];
            end
          end
        end
        fired_count += fired;
        r = '0;
        r.result_kind   = RES_SUMMARY;
        r.soonest_us    = soon;
        r.soonest_valid = any_left;
        r.last          = 1'b1;
        awaited_results.push_back(r);
      end
    endcase
  endtask

  task automatic send_item(input in_item_t it);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predict_timer_results(it);
    items_sent++;
  endtask

  task automatic wait_until_drained();
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int idx,
                             input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d field %s: got %h, want %h", idx, name, got, want));
  endtask

  // Result side: stall at random, with one long hold-off on request.
  initial begin : result_sink
    int n;
    logic held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = pick_gap();
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin : result_checker
    out_item_t got;
    out_item_t want;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = out_ch.data;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result %h arrived with nothing awaited", got));
        end else begin
          want = awaited_results.pop_front();
          check_field("result_kind",   results_seen, 64'(got.result_kind),   64'(want.result_kind));
          check_field("slot_out",      results_seen, 64'(got.slot_out),      64'(want.slot_out));
          check_field("gen_out",       results_seen, 64'(got.gen_out),       64'(want.gen_out));
          check_field("soonest_us",    results_seen, 64'(got.soonest_us),    64'(want.soonest_us));
          check_field("soonest_valid", results_seen, 64'(got.soonest_valid), 64'(want.soonest_valid));
          check_field("last",          results_seen, 64'(got.last),          64'(want.last));
        end
        results_seen++;
      end
    end
  end

  task automatic test_basic_timers();
    send_item(make_item(KIND_ADD, '0, 1'b0, '0, '0, '0));
    send_item(make_item(KIND_ADD, '1, 1'b1, '0, '0, '0));
    send_item(make_item(KIND_TICK, '0, 1'b0, '0, '0, 48'd999));
    send_item(make_item(KIND_TICK, '0, 1'b0, '0, '0, 48'd1000));
    send_item(make_item(KIND_CANCEL, '0, 1'b0, 4'd1, 32'd1, '0));
    // same handle again is now stale
    send_item(make_item(KIND_CANCEL, '0, 1'b0, 4'd1, 32'd1, '0));
    send_item(make_item(KIND_CANCEL, '0, 1'b0, 4'd15, '1, '0));
    send_item(make_item(KIND_TICK, '0, 1'b0, '0, '0, 48'd2000));
    send_item(make_item(KIND_CLEAR, '0, 1'b0, '0, '0, '0));
  endtask

  task automatic test_full_table();
    logic [TimeW-1:0] t0;
    int s;
    t0 = 48'h0000_1000_0000;
    for (s = 0; s < NUM_SLOTS; s++)
      send_item(make_item(KIND_ADD, MsW'(s), s[0], '0, '0, t0));
    send_item(make_item(KIND_ADD, 24'd5, 1'b1, '0, '0, t0));
    // every slot is due: one fired item per slot, periodic ones re-arm
    send_item(make_item(KIND_TICK, '0, 1'b0, '0, '0, t0 + 48'd15000));
    send_item(make_item(KIND_CANCEL, '0, 1'b0, 4'd3, tbl_gen[3], '0));
    send_item(make_item(KIND_CLEAR, '0, 1'b0, '0, '0, '0));
  endtask

  task automatic test_deadline_saturation();
    logic [TimeW-1:0] top;
    top = {TimeW{1'b1}};
    send_item(make_item(KIND_ADD, '1, 1'b1, '0, '0, top - 48'd10));
    send_item(make_item(KIND_ADD, '0, 1'b0, '0, '0, top - 48'd10));
    send_item(make_item(KIND_TICK, '0, 1'b0, '0, '0, top));
    send_item(make_item(KIND_CLEAR, '1, 1'b1, '1, '1, top));
  endtask

  function automatic in_item_t random_timer_item();
    in_item_t   it;
    int         r;
    int         s;
    int         live [$];
    it.kind        = KIND_ADD;
    it.delay_ms    = MsW'($urandom);
    it.repeating   = 1'($urandom);
    it.handle_slot = 4'($urandom);
    it.handle_gen  = $urandom;
    it.now_us      = wall_us;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      r = $urandom_range(0, 9);
      if (r < 7) it.delay_ms = MsW'($urandom_range(0, 20));
      else if (r < 9) it.delay_ms = MsW'($urandom_range(0, 200));
    end else if (r < 70) begin
      it.kind = KIND_TICK;
      wall_us = wall_us + 48'($urandom_range(0, 25000));
      it.now_us = wall_us;
    end else if (r < 90) begin
      it.kind = KIND_CANCEL;
      for (s = 0; s < NUM_SLOTS; s++) if (tbl_active[s]) live.push_back(s);
      if (live.size() != 0 && $urandom_range(0, 9) < 6) begin
        s = live[$urandom_range(0, live.size() - 1)];
        it.handle_slot = 4'(s);
        it.handle_gen  = tbl_gen[s];
      end else if ($urandom_range(0, 1) == 1) begin
        it.handle_gen = tbl_gen[it.handle_slot] - 1'b1;
      end
    end else if (r < 93) begin
      it.kind = KIND_CLEAR;
    end else begin
      // noise: any kind at any time value
      it.kind   = item_kind_t'($urandom_range(0, 3));
      it.now_us = 48'({$urandom, $urandom});
    end
    return it;
  endfunction

  task automatic test_random_traffic(input int count);
    int i;
    wall_us = {16'($urandom_range(0, 16'h7fff)), 32'($urandom)};
    for (i = 0; i < count; i++) send_item(random_timer_item());
  endtask

  task automatic test_output_backpressure();
    int i;
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    for (i = 0; i < 30; i++) send_item(random_timer_item());
    no_gaps = 1'b0;
  endtask

  initial begin : main
    int s;
    for (s = 0; s < NUM_SLOTS; s++) begin
      tbl_active[s]   = 1'b0;
      tbl_deadline[s] = '0;
      tbl_period[s]   = '0;
      tbl_gen[s]      = '0;
    end
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_timers();
    test_full_table();
    test_deadline_saturation();
    test_random_traffic(420);
    test_output_backpressure();

    in_ch.valid <= 1'b0;
    wait_until_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("summary: %0d items sent, %0d results checked, %0d timers fired",
             items_sent, results_seen, fired_count);
    $display("summary: %0d adds refused on a full table, %0d cancels freed a slot",
             full_count, cancel_hits);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("%0d mismatches", err_count);
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/stt_pkg.sv
hdl/stt_if.sv
hdl/stt_slot_eval.sv
hdl/software_timer_slot_table_core.sv
hdl/stt_checker.sv
tb/tb.sv
